>>> sv/stb_pkg.sv
`default_nettype none

package stb_pkg;

	// Pool size default and result limit per tick
	localparam int NUM_TIMERS_DEF = 32;
	localparam int MAX_RESULTS    = 32;
	localparam int RC_W           = $clog2(MAX_RESULTS + 1);

	// Stream widths
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 24;

	typedef enum logic [2:0] {
		CMD_ALLOC   = 3'd0,
		CMD_FREE    = 3'd1,
		CMD_SETDATA = 3'd2,
		CMD_SETTMO  = 3'd3,
		CMD_TICK    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FREE  = 2'd0,
		ST_ALLOC = 2'd1,
		ST_RUN   = 2'd2
	} status_t;

	localparam logic KIND_ALLOC  = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	// Command broadcast to every cell
	typedef struct packed {
		logic        valid;
		cmd_t        cmd;
		logic [4:0]  slot_index;
		logic [3:0]  dest_queue;
		logic [7:0]  data_value;
		logic [31:0] timeout;
	} bcast_t;

	// Scan control shared by the cells
	typedef struct packed {
		logic start;
		logic adv;
		logic claim;
	} scan_t;

	// What the cell holding the token shows; all zero elsewhere
	typedef struct packed {
		logic       is_free;
		logic       expired;
		logic [3:0] queue;
		logic [7:0] payload;
	} probe_t;

endpackage

`default_nettype wire

>>> sv/stb_cell.sv
`default_nettype none

module stb_cell
	import stb_pkg::*;
#(
	parameter int CELL_IDX = 0
) (
	input  wire    clk,
	input  wire    arst_n,
	input  bcast_t bcast,
	input  scan_t  scan,
	input  wire    token_prev,
	output logic   token,
	output probe_t probe
);

	status_t     status_q;
	logic        expired_q;
	logic        token_q;
	logic [31:0] rem_q;
	logic [3:0]  queue_q;
	logic [7:0]  payload_q;
	logic        sel;
	logic [31:0] rem_dec;

	assign sel     = bcast.valid && (int'(bcast.slot_index) == CELL_IDX);
	assign rem_dec = rem_q - 32'd1;
	assign token   = token_q;

	// Show own state only while holding the token
	always_comb begin
		probe.is_free = token_q && (status_q == ST_FREE);
		probe.expired = token_q && expired_q;
		probe.queue   = token_q ? queue_q : 4'd0;
		probe.payload = token_q ? payload_q : 8'd0;
	end

	// Status, expiry flag and scan token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= ST_FREE;
			expired_q <= 1'b0;
			token_q   <= 1'b0;
		end else begin
			if (scan.start) begin
				token_q <= (CELL_IDX == 0);
			end else if (scan.adv) begin
				token_q <= token_prev;
			end
			if (scan.claim && token_q) begin
				status_q <= ST_ALLOC;
			end
			if (bcast.valid) begin
				case (bcast.cmd)
					CMD_FREE: begin
						if (sel) status_q <= ST_FREE;
					end
					CMD_SETTMO: begin
						if (sel) status_q <= ST_RUN;
					end
					CMD_TICK: begin
						if (status_q == ST_RUN && rem_dec == 32'd0) begin
							status_q  <= ST_ALLOC;
							expired_q <= 1'b1;
						end else begin
							expired_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Countdown and stored destination
	always_ff @(posedge clk) begin
		if (bcast.valid) begin
			case (bcast.cmd)
				CMD_SETDATA: begin
					if (sel) begin
						queue_q   <= bcast.dest_queue;
						payload_q <= bcast.data_value;
					end
				end
				CMD_SETTMO: begin
					if (sel) rem_q <= bcast.timeout;
				end
				CMD_TICK: begin
					if (status_q == ST_RUN) rem_q <= rem_dec;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/stb_ctrl.sv
`default_nettype none

module stb_ctrl
	import stb_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire  [S_TDATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata,
	output logic                  m_axis_tuser,
	output logic                  m_axis_tlast,
	output bcast_t                bcast,
	output scan_t                 scan,
	input  probe_t                probe
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC,
		S_TICK,
		S_FLUSH
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   pos_q;
	logic [RC_W-1:0] rep_cnt_q;
	logic            pend_valid_q;
	logic [4:0]      pend_slot_q;
	logic [3:0]      pend_queue_q;
	logic [7:0]      pend_payload_q;
	logic            m_valid_q;
	logic            m_kind_q;
	logic [4:0]      m_slot_q;
	logic            m_fail_q;
	logic [3:0]      m_queue_q;
	logic [7:0]      m_payload_q;
	logic            m_last_q;

	logic            accept;
	logic            out_ok;
	logic            last_pos;
	logic [IW+4:0]   pos_ext;
	logic [4:0]      pos_slot;
	logic            capture;
	logic            emit;
	logic            emit_kind;
	logic [4:0]      emit_slot;
	logic            emit_fail;
	logic [3:0]      emit_queue;
	logic [7:0]      emit_payload;
	logic            emit_last;
	logic            step;

	// Unpack the input item
	assign s_axis_tready    = (state_q == S_IDLE);
	assign accept           = s_axis_tvalid && s_axis_tready;
	assign bcast.valid      = accept;
	assign bcast.cmd        = cmd_t'(s_axis_tdata[2:0]);
	assign bcast.slot_index = s_axis_tdata[7:3];
	assign bcast.dest_queue = s_axis_tdata[11:8];
	assign bcast.data_value = s_axis_tdata[19:12];
	assign bcast.timeout    = s_axis_tdata[51:20];

	assign out_ok   = !m_valid_q || m_axis_tready;
	assign last_pos = (pos_q == IW'(NUM_TIMERS - 1));
	assign pos_ext  = (IW + 5)'(pos_q);
	assign pos_slot = pos_ext[4:0];
	assign capture  = probe.expired && (rep_cnt_q < RC_W'(MAX_RESULTS));

	// Decide this cycle's scan step and any result to emit
	always_comb begin
		emit         = 1'b0;
		emit_kind    = KIND_ALLOC;
		emit_slot    = 5'd0;
		emit_fail    = 1'b0;
		emit_queue   = 4'd0;
		emit_payload = 8'd0;
		emit_last    = 1'b1;
		step         = 1'b0;
		scan.start   = accept && (bcast.cmd == CMD_ALLOC || bcast.cmd == CMD_TICK);
		scan.adv     = 1'b0;
		scan.claim   = 1'b0;
		case (state_q)
			S_ALLOC: begin
				if (probe.is_free || last_pos) begin
					emit       = out_ok;
					emit_slot  = probe.is_free ? pos_slot : 5'd0;
					emit_fail  = !probe.is_free;
					scan.claim = probe.is_free && out_ok;
				end else begin
					scan.adv = 1'b1;
				end
			end
			S_TICK: begin
				step = !(capture && pend_valid_q && !out_ok);
				if (capture && pend_valid_q) begin
					emit         = out_ok;
					emit_kind    = KIND_EXPIRY;
					emit_slot    = pend_slot_q;
					emit_queue   = pend_queue_q;
					emit_payload = pend_payload_q;
					emit_last    = 1'b0;
				end
				scan.adv = step && !last_pos;
			end
			S_FLUSH: begin
				if (pend_valid_q) begin
					emit         = out_ok;
					emit_kind    = KIND_EXPIRY;
					emit_slot    = pend_slot_q;
					emit_queue   = pend_queue_q;
					emit_payload = pend_payload_q;
				end
			end
			default: ;
		endcase
	end

	// Hold state, scan position, pending event and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pos_q        <= '0;
			rep_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (scan.start) begin
						pos_q        <= '0;
						rep_cnt_q    <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= (bcast.cmd == CMD_ALLOC) ? S_ALLOC : S_TICK;
					end
				end
				S_ALLOC: begin
					if (emit) begin
						state_q <= S_IDLE;
					end else if (scan.adv) begin
						pos_q <= pos_q + IW'(1);
					end
				end
				S_TICK: begin
					if (step) begin
						if (capture) begin
							pend_valid_q   <= 1'b1;
							pend_slot_q    <= pos_slot;
							pend_queue_q   <= probe.queue;
							pend_payload_q <= probe.payload;
							rep_cnt_q      <= rep_cnt_q + RC_W'(1);
						end
						if (last_pos) begin
							state_q <= S_FLUSH;
						end else begin
							pos_q <= pos_q + IW'(1);
						end
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q || emit) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (emit) begin
				m_valid_q   <= 1'b1;
				m_kind_q    <= emit_kind;
				m_slot_q    <= emit_slot;
				m_fail_q    <= emit_fail;
				m_queue_q   <= emit_queue;
				m_payload_q <= emit_payload;
				m_last_q    <= emit_last;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = {6'd0, m_payload_q, m_queue_q, m_fail_q, m_slot_q};

endmodule

`default_nettype wire

>>> sv/software_timer_bank_core.sv
`default_nettype none

// Pool of NUM_TIMERS countdown timers, one cell per slot in a row. Alloc
// claims the lowest free slot and answers with one item (alloc_failed set
// and slot 0 when none is free); free, set data and set timeout give no
// item. A tick decrements every running slot at once, then a token walks
// the row one cell per cycle while the output side does not stall and
// reports each expiring slot, up to MAX_RESULTS, in index order, the final
// one with tlast. Input and output are parted by an output register, so an
// item can be accepted while the previous result still waits.
module software_timer_bank_core
	import stb_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	// cmd[2:0], slot_index[7:3], dest_queue[11:8], data_value[19:12],
	// timeout[51:20], zero pad
	input  wire  [S_TDATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	// slot_number[4:0], alloc_failed[5], target_queue[9:6], payload[17:10],
	// zero pad
	output logic [M_TDATA_W-1:0]  m_axis_tdata,
	// result_kind[0]
	output logic                  m_axis_tuser,
	output logic                  m_axis_tlast
);

	bcast_t                bcast;
	scan_t                 scan;
	probe_t                probe;
	probe_t                probe_arr [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] token;

	stb_ctrl #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.bcast        (bcast),
		.scan         (scan),
		.probe        (probe)
	);

	// Row of slot cells, token handed from each cell to the next
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		stb_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bcast     (bcast),
			.scan      (scan),
			.token_prev((i == 0) ? 1'b0 : token[(i == 0) ? 0 : i - 1]),
			.token     (token[i]),
			.probe     (probe_arr[i])
		);
	end

	// Merge the probes; only the token holder drives nonzero bits
	always_comb begin
		logic [$bits(probe_t)-1:0] acc;
		acc = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			acc = acc | probe_arr[i];
		end
		probe = probe_t'(acc);
	end

	// At most one cell holds the scan token
	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(token))
		else $error("scan token held by more than one cell");

	// An allocation reply always closes its item
	a_alloc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_ALLOC) |-> m_axis_tlast)
		else $error("allocation reply without tlast");

	// A failed alloc reports slot zero, and expiry events never fail
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[5] |->
			(m_axis_tdata[4:0] == 5'd0) && (m_axis_tuser == KIND_ALLOC))
		else $error("bad failed-alloc reply");

	// A scanning command blocks the input in the following cycle
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready &&
		(s_axis_tdata[2:0] == CMD_ALLOC || s_axis_tdata[2:0] == CMD_TICK)
		|=> !s_axis_tready)
		else $error("input accepted during scan");

endmodule

`default_nettype wire
